[rtl/pctb_pkg.sv]
// Package for the prescaled countdown timer bank.
// Holds the command codes, controller states, register indexes and the
// controller/datapath handshake structs. No dependencies.
`default_nettype none

package pctb_pkg;

	localparam int unsigned FIELD_W_MS   = 16;
	localparam int unsigned FIELD_W_TICK = 32;
	localparam int unsigned RES_W        = 8;
	localparam int unsigned MASK_W       = 8;
	localparam int unsigned DIV_STEPS    = FIELD_W_MS;
	localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_SET    = 2'd1,
		FUNC_EXPIRE = 2'd2,
		FUNC_READ   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_APPLY,
		ST_REPORT
	} state_t;

	localparam logic REG_RESOLUTION = 1'b0;
	localparam logic REG_RUNNING    = 1'b1;

	typedef struct packed {
		logic load;
		logic div_step;
		logic apply;
		logic report;
	} cmd_t;

	typedef struct packed {
		logic is_set;
	} status_t;

	typedef struct packed {
		logic [RES_W-1:0] resolution;
		logic             running;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/pctb_regs.sv]
// Configuration register file of the timer bank behind the APB-style port.
// Depends on pctb_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module pctb_regs
	import pctb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [RES_W-1:0] resolution_q;
	logic             running_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolution_q <= RES_W'(1);
			running_q    <= 1'b1;
		end else if (wr_en) begin
			case (paddr[2])
				REG_RESOLUTION: resolution_q <= pwdata[RES_W-1:0];
				REG_RUNNING:    running_q    <= pwdata[0];
				default:        resolution_q <= resolution_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_RESOLUTION: prdata = {{(32-RES_W){1'b0}}, resolution_q};
			REG_RUNNING:    prdata = {31'b0, running_q};
			default:        prdata = 32'b0;
		endcase
	end

	assign cfg.resolution = resolution_q;
	assign cfg.running    = running_q;

endmodule

`default_nettype wire

[rtl/pctb_ctrl.sv]
// Controller state machine of the timer bank: sequences capture, the
// bit-serial divide for set commands, the state update and the result report.
// Depends on pctb_pkg for state_t, cmd_t and status_t.
`default_nettype none

module pctb_ctrl
	import pctb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire status_t status,
	output cmd_t         cmd,
	output logic         busy,
	output logic         done
);

	state_t               state_q;
	state_t               state_nxt;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 div_last;

	assign div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = status.is_set ? ST_DIVIDE : ST_APPLY;
				end
			end
			ST_DIVIDE: begin
				if (div_last) begin
					state_nxt = ST_APPLY;
				end
			end
			ST_APPLY:  state_nxt = ST_REPORT;
			ST_REPORT: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DIVIDE: cmd.div_step = 1'b1;
			ST_APPLY:  cmd.apply    = 1'b1;
			ST_REPORT: cmd.report   = 1'b1;
			default:   busy         = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done    <= cmd.report;
			if (state_q == ST_DIVIDE) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/pctb_dp.sv]
// Datapath of the timer bank: command capture, restoring divider, timer
// counters, prescaler, tick counter and result registers.
// Depends on pctb_pkg for func_t, cmd_t, status_t and cfg_t.
`default_nettype none

module pctb_dp
	import pctb_pkg::*;
#(
	parameter int unsigned NUM_TIMERS = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cmd_t                    cmd,
	output status_t                      status,
	input  wire cfg_t                    cfg,
	input  wire logic [1:0]              func,
	input  wire logic [3:0]              timer_id,
	input  wire logic [FIELD_W_MS-1:0]   duration,
	input  wire logic [FIELD_W_TICK-1:0] reference_tick,
	output logic                         addressed_running,
	output logic [MASK_W-1:0]            running_mask,
	output logic [FIELD_W_TICK-1:0]      tick_value,
	output logic [FIELD_W_TICK-1:0]      elapsed_ticks
);

	localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	func_t                   func_q;
	logic [3:0]              id_q;
	logic [FIELD_W_MS-1:0]   ms_q;
	logic [FIELD_W_TICK-1:0] ref_q;
	logic [FIELD_W_MS-1:0]   quo_q;
	logic [RES_W-1:0]        rem_q;

	logic [FIELD_W_MS-1:0]   remaining_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]   active_q;
	logic [RES_W-1:0]        prescale_q;
	logic [FIELD_W_TICK-1:0] tick_q;

	logic [RES_W-1:0]        eff_res;
	logic [RES_W:0]          shifted;
	logic                    sub_ok;
	logic                    id_valid;
	logic [IDX_W-1:0]        idx;
	logic [RES_W-1:0]        prescale_inc;
	logic                    fire;
	logic [MASK_W-1:0]       mask;

	assign status.is_set = (func_t'(func) == FUNC_SET);

	assign eff_res  = (cfg.resolution == '0) ? RES_W'(1) : cfg.resolution;
	assign shifted  = {rem_q, quo_q[FIELD_W_MS-1]};
	assign sub_ok   = (shifted >= {1'b0, eff_res});
	assign id_valid = ({1'b0, id_q} < 5'(NUM_TIMERS));
	assign idx      = id_q[IDX_W-1:0];

	assign prescale_inc = prescale_q + RES_W'(1);
	assign fire         = (prescale_inc >= eff_res);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(func);
			id_q   <= timer_id;
			ms_q   <= duration;
			ref_q  <= reference_tick;
			quo_q  <= duration;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[FIELD_W_MS-2:0], sub_ok};
			rem_q <= sub_ok ? RES_W'(shifted - {1'b0, eff_res}) : shifted[RES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				remaining_q[i] <= '0;
			end
			active_q   <= '0;
			prescale_q <= '0;
			tick_q     <= '0;
		end else if (cmd.apply) begin
			case (func_q)
				FUNC_TICK: begin
					tick_q     <= tick_q + FIELD_W_TICK'(1);
					prescale_q <= fire ? '0 : prescale_inc;
					if (fire) begin
						for (int i = 0; i < NUM_TIMERS; i++) begin
							if (active_q[i]) begin
								remaining_q[i] <= remaining_q[i] - FIELD_W_MS'(1);
								if (remaining_q[i] == FIELD_W_MS'(1)) begin
									active_q[i] <= 1'b0;
								end
							end
						end
					end
				end
				FUNC_SET: begin
					if (id_valid) begin
						if (ms_q >= {{(FIELD_W_MS-RES_W){1'b0}}, eff_res}) begin
							remaining_q[idx] <= quo_q;
							active_q[idx]    <= (quo_q != '0);
						end else begin
							active_q[idx] <= 1'b0;
						end
					end
				end
				FUNC_EXPIRE: begin
					if (id_valid) begin
						remaining_q[idx] <= '0;
						active_q[idx]    <= 1'b0;
					end
				end
				FUNC_READ: tick_q <= tick_q;
				default:   tick_q <= tick_q;
			endcase
		end
	end

	for (genvar g = 0; g < MASK_W; g++) begin : g_mask
		if (g < NUM_TIMERS) begin : g_on
			assign mask[g] = active_q[g];
		end else begin : g_off
			assign mask[g] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.report) begin
			addressed_running <= id_valid && active_q[idx];
			running_mask      <= mask;
			tick_value        <= tick_q;
			elapsed_ticks     <= cfg.running ? (tick_q - ref_q) : '0;
		end
	end

endmodule

`default_nettype wire

[rtl/prescaled_countdown_timer_bank.sv]
// Prescaled countdown timer bank, top level.
// Sequence: start captures the command; set runs the 16-step bit-serial divide
// by the resolution; apply and report follow; done is registered from report.
// Commands do not overlap: busy is high from accept to report.
// done lasts one cycle and the receiver cannot stall it.
// Reset (arst_n low): all timers expired, counters zero, resolution 1, running 1.
`default_nettype none

module prescaled_countdown_timer_bank
	import pctb_pkg::*;
#(
	parameter int unsigned NUM_TIMERS = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [2:0]              paddr,
	input  wire logic [31:0]             pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              func,
	input  wire logic [3:0]              timer_id,
	input  wire logic [FIELD_W_MS-1:0]   duration,
	input  wire logic [FIELD_W_TICK-1:0] reference_tick,
	output logic                         done,
	output logic                         addressed_running,
	output logic [MASK_W-1:0]            running_mask,
	output logic [FIELD_W_TICK-1:0]      tick_value,
	output logic [FIELD_W_TICK-1:0]      elapsed_ticks
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	pctb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pctb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pctb_dp #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg               (cfg),
		.func              (func),
		.timer_id          (timer_id),
		.duration          (duration),
		.reference_tick    (reference_tick),
		.addressed_running (addressed_running),
		.running_mask      (running_mask),
		.tick_value        (tick_value),
		.elapsed_ticks     (elapsed_ticks)
	);

endmodule

`default_nettype wire

[rtl/pctb_chk.sv]
// Port-level checker for the timer bank command handshake and its bind.
// Depends on prescaled_countdown_timer_bank ports only.
`default_nettype none

module pctb_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic pready
);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("transfer accepted without going busy");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy raised without a start");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind prescaled_countdown_timer_bank pctb_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.pready (pready)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for prescaled_countdown_timer_bank.
// Drives commands over start/busy and registers over APB, and checks each done
// strobe against an in-bench predictor or a typed report. Depends on pctb_pkg.
`timescale 1ns / 1ps

module tb;
	import pctb_pkg::*;

	localparam int unsigned NUM_TIMERS  = 8;
	localparam int          PLAN_LEN    = 30;
	localparam int          NUM_SEGS    = 12;
	localparam int          SEG_ITEMS   = 75;
	localparam int          CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic              running;
		logic [MASK_W-1:0] mask;
		logic [31:0]       ticks;
		logic [31:0]       elapsed;
	} report_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		func_t       op;
		logic [3:0]  id;
		logic [15:0] ms;
		logic [31:0] ref_tick;
		logic        reg_sel;
		logic [7:0]  cfg_val;
		logic        typed;
		report_t     rep;
	} row_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        psel           = 1'b0;
	logic        penable        = 1'b0;
	logic        pwrite         = 1'b0;
	logic [2:0]  paddr          = '0;
	logic [31:0] pwdata         = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start          = 1'b0;
	logic        busy;
	func_t       func           = FUNC_TICK;
	logic [3:0]  timer_id       = '0;
	logic [15:0] duration       = '0;
	logic [31:0] reference_tick = '0;
	logic        done;
	logic        addressed_running;
	logic [7:0]  running_mask;
	logic [31:0] tick_value;
	logic [31:0] elapsed_ticks;

	logic [15:0] bank_left [NUM_TIMERS];
	logic        bank_on   [NUM_TIMERS];
	logic [7:0]  bank_presc;
	logic [31:0] bank_ticks;
	logic [7:0]  bank_res;
	logic        bank_run;

	report_t     pending_reports [$];
	report_t     want;
	int          errors      = 0;
	int          cycle_count = 0;
	row_t        plan [0:PLAN_LEN-1];
	logic [7:0]  res_plan [0:NUM_SEGS-1] = '{8'd1, 8'd2, 8'd255, 8'd0, 8'd3, 8'd1,
		8'd7, 8'd1, 8'd128, 8'd0, 8'd2, 8'd1};

	prescaled_countdown_timer_bank #(
		.NUM_TIMERS(NUM_TIMERS)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.start            (start),
		.busy             (busy),
		.func             (func),
		.timer_id         (timer_id),
		.duration         (duration),
		.reference_tick   (reference_tick),
		.done             (done),
		.addressed_running(addressed_running),
		.running_mask     (running_mask),
		.tick_value       (tick_value),
		.elapsed_ticks    (elapsed_ticks)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic report_t apply_timer_op(input func_t f, input logic [3:0] id,
			input logic [15:0] ms, input logic [31:0] ref_tick);
		report_t    rep;
		logic [7:0] res;
		logic       valid;
		int         i;
		res   = (bank_res == 8'd0) ? 8'd1 : bank_res;
		valid = (id < NUM_TIMERS);
		case (f)
			FUNC_TICK: begin
				bank_ticks = bank_ticks + 32'd1;
				bank_presc = bank_presc + 8'd1;
				if (bank_presc >= res) begin
					bank_presc = 8'd0;
					for (i = 0; i < NUM_TIMERS; i++) begin
						if (bank_on[i]) begin
							bank_left[i] = bank_left[i] - 16'd1;
							if (bank_left[i] == 16'd0)
								bank_on[i] = 1'b0;
						end
					end
				end
			end
			FUNC_SET: begin
				if (valid) begin
					bank_on[id[2:0]] = 1'b0;
					if (ms >= {8'd0, res}) begin
						bank_left[id[2:0]] = ms / {8'd0, res};
						if (bank_left[id[2:0]] != 16'd0)
							bank_on[id[2:0]] = 1'b1;
					end
				end
			end
			FUNC_EXPIRE: begin
				if (valid) begin
					bank_left[id[2:0]] = 16'd0;
					bank_on[id[2:0]]   = 1'b0;
				end
			end
			default: ;
		endcase
		rep.mask = '0;
		for (i = 0; i < NUM_TIMERS && i < MASK_W; i++)
			rep.mask[i] = bank_on[i];
		rep.running = valid ? bank_on[id[2:0]] : 1'b0;
		rep.ticks   = bank_ticks;
		rep.elapsed = bank_run ? bank_ticks - ref_tick : 32'd0;
		return rep;
	endfunction

	task automatic issue_cmd(input func_t f, input logic [3:0] id, input logic [15:0] ms,
			input logic [31:0] ref_tick, input logic typed, input report_t typed_rep,
			input int idle_pct);
		report_t rep;
		int      idle;
		start          <= 1'b1;
		func           <= f;
		timer_id       <= id;
		duration       <= ms;
		reference_tick <= ref_tick;
		do @(posedge clk); while (busy);
		rep = apply_timer_op(f, id, ms, ref_tick);
		pending_reports.push_back(typed ? typed_rep : rep);
		idle = 0;
		while ($urandom_range(0, 99) < idle_pct)
			idle++;
		if (idle != 0) begin
			start <= 1'b0;
			repeat (idle) @(posedge clk);
		end
	endtask

	task automatic drain_reports();
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic reg_sel, input logic [7:0] val);
		logic [31:0] rnd;
		logic [31:0] data;
		rnd  = $urandom;
		data = (reg_sel == REG_RESOLUTION) ? {rnd[31:8], val} : {rnd[31:1], val[0]};
		drain_reports();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == REG_RESOLUTION)
			bank_res = data[7:0];
		else
			bank_run = data[0];
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_reports.size() == 0) begin
				$error("done strobe with no transfer pending");
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (addressed_running !== want.running) begin
					$error("addressed_running: expected %0d, got %0d", want.running,
						addressed_running);
					errors++;
				end
				if (running_mask !== want.mask) begin
					$error("running_mask: expected %h, got %h", want.mask, running_mask);
					errors++;
				end
				if (tick_value !== want.ticks) begin
					$error("tick_value: expected %h, got %h", want.ticks, tick_value);
					errors++;
				end
				if (elapsed_ticks !== want.elapsed) begin
					$error("elapsed_ticks: expected %h, got %h", want.elapsed, elapsed_ticks);
					errors++;
				end
			end
		end
	end

	initial begin
		int          n;
		int          seg;
		int          k;
		int          r;
		int          pct;
		int          eff;
		func_t       f;
		logic [3:0]  id;
		logic [15:0] ms;
		logic [31:0] ref_tick;

		for (n = 0; n < NUM_TIMERS; n++) begin
			bank_left[n] = '0;
			bank_on[n]   = 1'b0;
		end
		bank_presc = '0;
		bank_ticks = '0;
		bank_res   = 8'd1;
		bank_run   = 1'b1;

		plan = '{
			'{ROW_ITEM, FUNC_READ,   4'd0,  16'd0,     32'd0,        1'b0, 8'd0, 1'b1,
				'{1'b0, 8'h00, 32'd0, 32'd0}},
			'{ROW_ITEM, FUNC_READ,   4'd15, 16'd0,     32'hFFFFFFFF, 1'b0, 8'd0, 1'b1,
				'{1'b0, 8'h00, 32'd0, 32'd1}},
			'{ROW_ITEM, FUNC_EXPIRE, 4'd0,  16'd0,     32'd0,        1'b0, 8'd0, 1'b1,
				'{1'b0, 8'h00, 32'd0, 32'd0}},
			'{ROW_ITEM, FUNC_SET,    4'd0,  16'd3,     32'd0,        1'b0, 8'd0, 1'b1,
				'{1'b1, 8'h01, 32'd0, 32'd0}},
			'{ROW_ITEM, FUNC_SET,    4'd7,  16'hFFFF,  32'd0,        1'b0, 8'd0, 1'b1,
				'{1'b1, 8'h81, 32'd0, 32'd0}},
			'{ROW_ITEM, FUNC_SET,    4'd8,  16'd100,   32'd0,        1'b0, 8'd0, 1'b1,
				'{1'b0, 8'h81, 32'd0, 32'd0}},
			'{ROW_ITEM, FUNC_SET,    4'd15, 16'hFFFF,  32'd0,        1'b0, 8'd0, 1'b1,
				'{1'b0, 8'h81, 32'd0, 32'd0}},
			'{ROW_ITEM, FUNC_TICK,   4'd0,  16'd0,     32'd0,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_ITEM, FUNC_TICK,   4'd0,  16'hFFFF,  32'h80000000, 1'b0, 8'd0, 1'b0, '0},
			'{ROW_ITEM, FUNC_TICK,   4'd0,  16'd0,     32'd0,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_ITEM, FUNC_SET,    4'd3,  16'd0,     32'd0,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_ITEM, FUNC_EXPIRE, 4'd7,  16'd0,     32'd3,        1'b0, 8'd0, 1'b1,
				'{1'b0, 8'h00, 32'd3, 32'd0}},
			'{ROW_ITEM, FUNC_EXPIRE, 4'd9,  16'd0,     32'd0,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_CFG,  FUNC_READ,   4'd0,  16'd0,     32'd0,  REG_RESOLUTION, 8'd255, 1'b0, '0},
			'{ROW_ITEM, FUNC_SET,    4'd1,  16'd254,   32'd0,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_ITEM, FUNC_SET,    4'd2,  16'hFFFF,  32'd0,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_ITEM, FUNC_TICK,   4'd2,  16'd0,     32'd2,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_CFG,  FUNC_READ,   4'd0,  16'd0,     32'd0,  REG_RESOLUTION, 8'd0,   1'b0, '0},
			'{ROW_ITEM, FUNC_SET,    4'd4,  16'd5,     32'd0,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_ITEM, FUNC_TICK,   4'd4,  16'd0,     32'd0,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_CFG,  FUNC_READ,   4'd0,  16'd0,     32'd0,  REG_RUNNING,    8'd0,   1'b0, '0},
			'{ROW_ITEM, FUNC_READ,   4'd4,  16'd0,     32'h12345678, 1'b0, 8'd0, 1'b0, '0},
			'{ROW_CFG,  FUNC_READ,   4'd0,  16'd0,     32'd0,  REG_RUNNING,    8'd1,   1'b0, '0},
			'{ROW_CFG,  FUNC_READ,   4'd0,  16'd0,     32'd0,  REG_RESOLUTION, 8'd200, 1'b0, '0},
			'{ROW_ITEM, FUNC_TICK,   4'd5,  16'd0,     32'hFFFFFFFF, 1'b0, 8'd0, 1'b0, '0},
			'{ROW_ITEM, FUNC_TICK,   4'd6,  16'd0,     32'd0,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_ITEM, FUNC_TICK,   4'd7,  16'd0,     32'd9,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_CFG,  FUNC_READ,   4'd0,  16'd0,     32'd0,  REG_RESOLUTION, 8'd2,   1'b0, '0},
			'{ROW_ITEM, FUNC_TICK,   4'd2,  16'd0,     32'd0,        1'b0, 8'd0, 1'b0, '0},
			'{ROW_ITEM, FUNC_READ,   4'd2,  16'd0,     32'd0,        1'b0, 8'd0, 1'b0, '0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < PLAN_LEN; n++) begin
			if (plan[n].kind == ROW_CFG)
				cfg_write(plan[n].reg_sel, plan[n].cfg_val);
			else
				issue_cmd(plan[n].op, plan[n].id, plan[n].ms, plan[n].ref_tick,
					plan[n].typed, plan[n].rep, 0);
		end

		for (seg = 0; seg < NUM_SEGS; seg++) begin
			cfg_write(REG_RESOLUTION, res_plan[seg]);
			cfg_write(REG_RUNNING, ($urandom_range(0, 3) != 0) ? 8'd1 : 8'd0);
			case (seg % 3)
				0:       pct = 0;
				1:       pct = 61;
				default: pct = 8;
			endcase
			for (k = 0; k < SEG_ITEMS; k++) begin
				eff = (bank_res == 8'd0) ? 1 : int'(bank_res);
				r   = $urandom_range(0, 99);
				if (r < 45)
					f = FUNC_TICK;
				else if (r < 70)
					f = FUNC_SET;
				else if (r < 80)
					f = FUNC_EXPIRE;
				else
					f = FUNC_READ;
				if ($urandom_range(0, 99) < 85)
					id = 4'($urandom_range(0, NUM_TIMERS - 1));
				else
					id = 4'($urandom_range(NUM_TIMERS, 15));
				r = $urandom_range(0, 99);
				if (r < 50)
					ms = 16'($urandom_range(0, 3 * eff + 2));
				else if (r < 60)
					ms = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				else
					ms = 16'($urandom);
				if ($urandom_range(0, 1))
					ref_tick = bank_ticks - 32'($urandom_range(0, 40));
				else
					ref_tick = $urandom;
				issue_cmd(f, id, ms, ref_tick, 1'b0, '0, pct);
			end
			// hold off until the bank has reported everything
			drain_reports();
		end

		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/pctb_pkg.sv
rtl/pctb_regs.sv
rtl/pctb_ctrl.sv
rtl/pctb_dp.sv
rtl/prescaled_countdown_timer_bank.sv
rtl/pctb_chk.sv
tb/tb.sv
